>>> design/mfde_pkg.sv
// Package for the monochrome frame-store draw engine: payload structs, command codes,
// controller states and the command/status structs between controller and datapath.
`default_nettype none
package mfde_pkg;
  localparam int unsigned FbColumnsDefault = 128;
  localparam int unsigned FbPagesDefault   = 8;

  typedef enum logic [2:0] {
    OP_PLOT   = 3'd0,
    OP_LINE   = 3'd1,
    OP_CIRCLE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic [7:0] radius;
    logic       pixel_on;
    logic [2:0] page;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [2:0] done_operation;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_SWEEP,      // clearing pass
    ST_IDLE,
    ST_PIX_RD,     // issue store read for a pixel
    ST_PIX_WR,     // modify and write the pixel byte
    ST_LINE_INIT,
    ST_LINE_STEP,  // decide next line pixel
    ST_CIRC_INIT,
    ST_CIRC_MUL,   // a/b update from the squares
    ST_CIRC_TEST,  // loop condition
    ST_CIRC_PT,    // select one of eight points
    ST_CIRC_ADV,   // next point, or compute squares after the last
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load;        // capture the command
    logic       sweep_clr;   // reset sweep address
    logic       sweep_wr;    // write zero at sweep address
    logic       pix_from_start; // point pixel at start coordinate
    logic       pix_from_walk;
    logic       pix_from_circ;
    logic       pix_rd;
    logic       pix_wr;
    logic       line_init;
    logic       line_step;
    logic       circ_init;
    logic       circ_mul;
    logic       circ_pt_next;
    logic       circ_adv;
    logic       read_rd;
    logic       read_cap;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic line_last;
    logic circ_zero;
    logic circ_go;
    logic circ_pt_last;
    op_e  op;
  } stat_t;
endpackage
`default_nettype wire

>>> design/mfde_datapath.sv
// Datapath of the draw engine: frame store memory, line walker, circle stepper.
// Depends on mfde_pkg; driven by mfde_ctrl through cmd_t and stat_t.
`default_nettype none
module mfde_datapath import mfde_pkg::*; #(
  parameter int unsigned FB_COLUMNS = FbColumnsDefault,
  parameter int unsigned FB_PAGES   = FbPagesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_word_t  in_word_i,
  input  wire cmd_t      cmd_i,
  output      stat_t     stat_o,
  output      logic [7:0] read_byte_o
);
  localparam int unsigned Bytes = FB_COLUMNS * FB_PAGES;
  localparam int unsigned AW    = (Bytes > 1) ? $clog2(Bytes) : 1;
  localparam int unsigned Rows  = FB_PAGES * 8;

  logic [7:0] mem_q [Bytes];
  logic [7:0] rdata_q;
  logic [AW:0] sweep_q;
  in_word_t cmd_q;

  // line walker
  logic [8:0] walk_x_q, walk_y_q;
  logic [9:0] err_x_q, err_y_q, step_q;
  logic [7:0] dx_q, dy_q, dist_q;
  logic       ix_neg_q, iy_neg_q, ix_nz_q, iy_nz_q;

  // circle stepper
  logic [7:0]  ca_q, cb_q;
  logic [16:0] aa_q, bb_q;
  logic [15:0] rr_q;
  logic [2:0]  pt_q;

  // current pixel
  logic [7:0] px_q, py_q;
  logic       pon_q;
  logic       in_view;
  logic [AW-1:0] paddr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] addr;
  logic [7:0]  mask;

  assign in_view = ({1'b0, px_q} < 9'(FB_COLUMNS)) && ({2'b0, py_q} < 10'(Rows));
  assign paddr  = AW'(({24'd0, px_q} * FB_PAGES) + ({24'd0, py_q} >> 3));
  assign raddr  = AW'(({24'd0, cmd_q.start_x} * FB_PAGES) + {29'd0, cmd_q.page});
  assign mask   = 8'(1) << py_q[2:0];

  always_comb begin
    addr = paddr;
    if (cmd_i.read_rd) addr = raddr;
  end

  // circle point selection
  logic [7:0] cpx, cpy;
  always_comb begin
    unique case (pt_q)
      3'd0: begin cpx = cmd_q.start_x + ca_q; cpy = cmd_q.start_y - cb_q; end
      3'd1: begin cpx = cmd_q.start_x - ca_q; cpy = cmd_q.start_y - cb_q; end
      3'd2: begin cpx = cmd_q.start_x - ca_q; cpy = cmd_q.start_y + cb_q; end
      3'd3: begin cpx = cmd_q.start_x + ca_q; cpy = cmd_q.start_y + cb_q; end
      3'd4: begin cpx = cmd_q.start_x + cb_q; cpy = cmd_q.start_y + ca_q; end
      3'd5: begin cpx = cmd_q.start_x + cb_q; cpy = cmd_q.start_y - ca_q; end
      3'd6: begin cpx = cmd_q.start_x - cb_q; cpy = cmd_q.start_y - ca_q; end
      default: begin cpx = cmd_q.start_x - cb_q; cpy = cmd_q.start_y + ca_q; end
    endcase
  end

  // Memory: one access per cycle, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_wr) begin
      mem_q[sweep_q[AW-1:0]] <= 8'd0;
    end else if (cmd_i.pix_wr && in_view) begin
      mem_q[paddr] <= pon_q ? (rdata_q | mask) : (rdata_q & ~mask);
    end
    if (cmd_i.pix_rd || cmd_i.read_rd) rdata_q <= mem_q[addr];
  end

  logic [9:0] ex_n, ey_n;
  logic [7:0] a_inc;
  assign ex_n = err_x_q + {2'd0, dx_q};
  assign ey_n = err_y_q + {2'd0, dy_q};
  assign a_inc = ca_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q  <= '0;
      walk_x_q <= '0;
      walk_y_q <= '0;
      err_x_q  <= '0;
      err_y_q  <= '0;
      step_q   <= '0;
      pt_q     <= '0;
      read_byte_o <= '0;
    end else begin
      if (cmd_i.sweep_clr) sweep_q <= '0;
      else if (cmd_i.sweep_wr) sweep_q <= sweep_q + 1'b1;
      if (cmd_i.load) read_byte_o <= 8'd0;
      if (cmd_i.read_cap) begin
        read_byte_o <= (({1'b0, cmd_q.start_x} < 9'(FB_COLUMNS)) &&
                        ({3'b0, cmd_q.page} < 6'(FB_PAGES))) ? rdata_q : 8'd0;
      end
      if (cmd_i.line_init) begin
        walk_x_q <= {1'b0, cmd_q.start_x};
        walk_y_q <= {1'b0, cmd_q.start_y};
        err_x_q  <= '0;
        err_y_q  <= '0;
        step_q   <= '0;
      end else if (cmd_i.line_step) begin
        step_q <= step_q + 10'd1;
        if (ex_n > {2'd0, dist_q}) begin
          err_x_q  <= ex_n - {2'd0, dist_q};
          walk_x_q <= ix_neg_q ? walk_x_q - 9'd1 : walk_x_q + {8'd0, ix_nz_q};
        end else err_x_q <= ex_n;
        if (ey_n > {2'd0, dist_q}) begin
          err_y_q  <= ey_n - {2'd0, dist_q};
          walk_y_q <= iy_neg_q ? walk_y_q - 9'd1 : walk_y_q + {8'd0, iy_nz_q};
        end else err_y_q <= ey_n;
      end
      if (cmd_i.circ_init || cmd_i.circ_adv) pt_q <= '0;
      else if (cmd_i.circ_pt_next) pt_q <= pt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_word_i;
      ix_neg_q <= in_word_i.end_x < in_word_i.start_x;
      iy_neg_q <= in_word_i.end_y < in_word_i.start_y;
      ix_nz_q  <= in_word_i.end_x != in_word_i.start_x;
      iy_nz_q  <= in_word_i.end_y != in_word_i.start_y;
      dx_q <= (in_word_i.end_x >= in_word_i.start_x) ? in_word_i.end_x - in_word_i.start_x
                                                     : in_word_i.start_x - in_word_i.end_x;
      dy_q <= (in_word_i.end_y >= in_word_i.start_y) ? in_word_i.end_y - in_word_i.start_y
                                                     : in_word_i.start_y - in_word_i.end_y;
    end
    if (cmd_i.line_init) dist_q <= (dx_q > dy_q) ? dx_q : dy_q;
    if (cmd_i.circ_init) begin
      ca_q <= 8'd0;
      cb_q <= cmd_q.radius;
      rr_q <= cmd_q.radius * cmd_q.radius;
    end else if (cmd_i.circ_adv) begin
      // a*a+b*b with a+1 is tested here via aa_q, squared in the circ_mul stage
      if ((aa_q + bb_q) > {1'b0, rr_q}) cb_q <= cb_q - 8'd1;
      else ca_q <= a_inc;
    end
    if (cmd_i.circ_mul) begin
      aa_q <= 17'(a_inc) * 17'(a_inc);
      bb_q <= 17'(cb_q) * 17'(cb_q);
    end
    if (cmd_i.pix_from_start) begin
      // A zero-radius circle sets its center whatever pixel_on says.
      px_q <= cmd_q.start_x; py_q <= cmd_q.start_y;
      pon_q <= cmd_q.pixel_on | (cmd_q.operation != OP_PLOT);
    end else if (cmd_i.pix_from_walk) begin
      px_q <= walk_x_q[7:0]; py_q <= walk_y_q[7:0]; pon_q <= 1'b1;
    end else if (cmd_i.pix_from_circ) begin
      px_q <= cpx; py_q <= cpy; pon_q <= 1'b1;
    end
  end

  always_comb begin
    stat_o.sweep_last = (sweep_q == (AW+1)'(Bytes - 1));
    stat_o.line_last  = (step_q == {2'd0, dist_q});
    stat_o.circ_zero  = (cmd_q.radius == 8'd0);
    // loop test 2*b*b >= r*r uses bb_q = b*b from the mul stage
    stat_o.circ_go    = ({bb_q, 1'b0} >= {2'd0, rr_q});
    stat_o.circ_pt_last = (pt_q == 3'd7);
    stat_o.op         = op_e'(cmd_q.operation);
  end
endmodule
`default_nettype wire

>>> design/mfde_ctrl.sv
// Controller state machine of the draw engine: sequences store accesses per command.
// Depends on mfde_pkg; drives mfde_datapath through cmd_t.
`default_nettype none
module mfde_ctrl import mfde_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_stall_o,
  output      logic  out_valid_o,
  input  wire logic  out_stall_i,
  input  wire stat_t stat_i,
  output      cmd_t  cmd_o
);
  state_e state_q, state_d;
  state_e ret_q, ret_d;   // where a pixel write or a sweep returns to
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      ret_q   <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign in_stall_o  = !(state_q == ST_IDLE) || ov_q;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        // The sweep after reset goes to idle, a clear command finishes with a result.
        if (stat_i.sweep_last) begin
          cmd_o.sweep_clr = 1'b1;
          state_d = ret_q;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && !ov_q) begin
          cmd_o.load = 1'b1;
          ret_d   = ST_DONE;
          // dispatch happens next cycle on the captured word
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // dispatch on the captured command
        unique case (stat_i.op)
          OP_PLOT: begin cmd_o.pix_from_start = 1'b1; ret_d = ST_DONE; state_d = ST_PIX_RD; end
          OP_LINE: begin cmd_o.line_init = 1'b1; state_d = ST_LINE_INIT; end
          OP_CIRCLE: begin
            cmd_o.circ_init = 1'b1;
            if (stat_i.circ_zero) begin
              cmd_o.pix_from_start = 1'b1; ret_d = ST_DONE; state_d = ST_PIX_RD;
            end else state_d = ST_CIRC_INIT;
          end
          OP_CLEAR: begin ret_d = ST_DONE; cmd_o.sweep_clr = 1'b1; state_d = ST_SWEEP; end
          OP_READ: begin cmd_o.read_rd = 1'b1; state_d = ST_READ_WAIT; end
          default: state_d = ST_DONE;
        endcase
      end
      ST_READ_WAIT: begin cmd_o.read_cap = 1'b1; state_d = ST_DONE; end
      ST_PIX_RD: begin cmd_o.pix_rd = 1'b1; state_d = ST_PIX_WR; end
      ST_PIX_WR: begin cmd_o.pix_wr = 1'b1; state_d = ret_q; end
      ST_LINE_INIT: begin
        cmd_o.pix_from_walk = 1'b1; ret_d = ST_LINE_STEP; state_d = ST_PIX_RD;
      end
      ST_LINE_STEP: begin
        if (stat_i.line_last) state_d = ST_DONE;
        else begin cmd_o.line_step = 1'b1; state_d = ST_LINE_INIT; end
      end
      ST_CIRC_INIT: begin cmd_o.circ_mul = 1'b1; state_d = ST_CIRC_TEST; end
      ST_CIRC_TEST: begin
        state_d = stat_i.circ_go ? ST_CIRC_PT : ST_DONE;
      end
      ST_CIRC_PT: begin
        cmd_o.pix_from_circ = 1'b1; ret_d = ST_CIRC_ADV; state_d = ST_PIX_RD;
      end
      ST_CIRC_ADV: begin
        if (stat_i.circ_pt_last) begin
          cmd_o.circ_mul = 1'b1; state_d = ST_CIRC_MUL;
        end else begin cmd_o.circ_pt_next = 1'b1; state_d = ST_CIRC_PT; end
      end
      ST_CIRC_MUL: begin
        // squares of a+1 and b now valid; update a/b and recompute
        cmd_o.circ_adv = 1'b1; state_d = ST_CIRC_INIT;
      end
      ST_DONE: begin
        if (!ov_q) begin ov_d = 1'b1; state_d = ST_IDLE; end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> design/monochrome_framebuffer_draw_engine.sv
// Top level of the monochrome frame-store draw engine.
// Depends on mfde_pkg, mfde_ctrl and mfde_datapath.
`default_nettype none
// Usage: one command word enters on in_word_i under in_valid_i/in_stall_o and exactly
// one result word leaves on out_word_o under out_valid_o/out_stall_i.
// A word is taken at a clock edge where valid is high and stall is low.
// Commands run one at a time; each frame store access goes through a single port with
// registered read data, and each pixel is a store read followed by a write.
// A clear writes one byte a cycle, a line draws max(|dx|,|dy|)+1 pixels, a zero-radius
// circle draws only its center, and any other circle draws eight points per a/b step.
// The result word stays until taken; a stall on the output only holds the result,
// and the next command can be accepted in the cycle after the result leaves the
// output register.
// After reset the block sweeps the whole store to zero, one byte a cycle, before it
// accepts its first command.
module monochrome_framebuffer_draw_engine import mfde_pkg::*; #(
  parameter int unsigned FB_COLUMNS = FbColumnsDefault,
  parameter int unsigned FB_PAGES   = FbPagesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_word_t  in_word_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_word_t out_word_o
);
  cmd_t  cmd;
  stat_t stat;
  logic [7:0] rbyte;

  mfde_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  mfde_datapath #(.FB_COLUMNS(FB_COLUMNS), .FB_PAGES(FB_PAGES)) u_dp (
    .clk_i, .rst_ni, .in_word_i, .cmd_i(cmd), .stat_o(stat), .read_byte_o(rbyte)
  );

  // Command code echo comes from the captured word.
  assign out_word_o = '{read_byte: rbyte, done_operation: stat.op};
endmodule
`default_nettype wire

>>> test/mfde_checker.sv
// Checker for the monochrome frame-store draw engine: watches both channels, keeps its
// own frame store and compares every result word. Depends on mfde_pkg.
module mfde_checker import mfde_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_o,
  input  wire in_word_t  in_word_i,
  input  wire logic      out_valid_o,
  input  wire logic      out_stall_i,
  input  wire out_word_t out_word_o,
  output int             fail_count,
  output int             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] pixels [1024];
  out_word_t  expected_q[$];

  assign pending_count = expected_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic void set_pixel(input int x, input int y, input bit on);
    int idx;
    if (x > 127 || y > 63) return;
    idx = x * 8 + y / 8;
    pixels[idx][y % 8] = on;
  endfunction

  function automatic void trace_line(input int x1, input int y1, input int x2, input int y2);
    int dx, dy, span, sx, sy, wx, wy, ex, ey;
    sx = (x2 > x1) ? 1 : (x2 == x1) ? 0 : -1;
    sy = (y2 > y1) ? 1 : (y2 == y1) ? 0 : -1;
    dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
    dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
    span = (dx > dy) ? dx : dy;
    wx = x1; wy = y1; ex = 0; ey = 0;
    for (int n = 0; n <= span; n++) begin
      set_pixel(wx & 255, wy & 255, 1'b1);
      ex += dx; ey += dy;
      if (ex > span) begin ex -= span; wx += sx; end
      if (ey > span) begin ey -= span; wy += sy; end
    end
  endfunction

  function automatic void trace_circle(input int cx, input int cy, input int r);
    int a, b, rr;
    a = 0; b = r; rr = r * r;
    if (r == 0) begin
      set_pixel(cx, cy, 1'b1);
      return;
    end
    while (2 * b * b >= rr) begin
      set_pixel((cx + a) & 255, (cy - b) & 255, 1'b1);
      set_pixel((cx - a) & 255, (cy - b) & 255, 1'b1);
      set_pixel((cx - a) & 255, (cy + b) & 255, 1'b1);
      set_pixel((cx + a) & 255, (cy + b) & 255, 1'b1);
      set_pixel((cx + b) & 255, (cy + a) & 255, 1'b1);
      set_pixel((cx + b) & 255, (cy - a) & 255, 1'b1);
      set_pixel((cx - b) & 255, (cy - a) & 255, 1'b1);
      set_pixel((cx - b) & 255, (cy + a) & 255, 1'b1);
      a++;
      if (a * a + b * b > rr) begin b--; a--; end
    end
  endfunction

  function automatic out_word_t run_command(input in_word_t w);
    out_word_t res;
    res.read_byte = '0;
    res.done_operation = w.operation;
    case (w.operation)
      OP_PLOT:   set_pixel(w.start_x, w.start_y, w.pixel_on);
      OP_LINE:   trace_line(w.start_x, w.start_y, w.end_x, w.end_y);
      OP_CIRCLE: trace_circle(w.start_x, w.start_y, w.radius);
      OP_CLEAR:  foreach (pixels[i]) pixels[i] = '0;
      OP_READ:   if (w.start_x < 128) res.read_byte = pixels[w.start_x * 8 + w.page];
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    fail_count = 0;
    foreach (pixels[i]) pixels[i] = '0;
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_q.push_back(run_command(in_word_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word, op", out_word_o.done_operation, -1);
        end else begin
          want = expected_q.pop_front();
          if (out_word_o.read_byte !== want.read_byte)
            report_mismatch("read_byte", out_word_o.read_byte, want.read_byte);
          if (out_word_o.done_operation !== want.done_operation)
            report_mismatch("done_operation", out_word_o.done_operation,
                            want.done_operation);
        end
      end
    end
  end
endmodule

>>> test/tb_monochrome_framebuffer_draw_engine.sv
// Top of the draw engine testbench: clock, reset, command stimulus and the verdict.
// Depends on mfde_pkg, the draw engine and mfde_checker.
module tb_monochrome_framebuffer_draw_engine;
  import mfde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InBits = $bits(in_word_t);

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;
  int        fail_count;
  int        pending_count;
  int        cycle_count;
  // Percent of cycles in which each side idles; zero during the calm stretch.
  int        idle_pct;

  monochrome_framebuffer_draw_engine DUT (.*);

  mfde_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and timeout. A worst case run is about 1400 words with stalls, and the
  // timeout leaves ample margin for it.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 4000000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // The receiver stalls at random, changing only on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // Offers one command word and holds it until the block takes it. Valid is left high
  // on return; the next call or the caller drops it when no word follows.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic in_word_t make_word(input logic [2:0] op, input int sx, input int sy,
                                         input int ex, input int ey, input int r,
                                         input bit on, input int pg);
    in_word_t w;
    w.operation = op;
    w.start_x = 8'(sx); w.start_y = 8'(sy); w.end_x = 8'(ex); w.end_y = 8'(ey);
    w.radius = 8'(r); w.pixel_on = on; w.page = 3'(pg);
    return w;
  endfunction

  // Coordinates mostly land on the screen, sometimes anywhere in the byte.
  function automatic int coord(input int lim);
    return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(lim);
  endfunction

  // Most random words draw and read back; long lines and big circles are rare.
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    w = in_word_t'(InBits'({$urandom(), $urandom()}));
    pick = $urandom_range(99);
    w.start_x = 8'(coord(127));
    w.start_y = 8'(coord(63));
    if (pick < 25) w.operation = OP_PLOT;
    else if (pick < 40) begin
      w.operation = OP_LINE;
      if ($urandom_range(7) == 0) begin
        w.end_x = 8'(coord(127)); w.end_y = 8'(coord(63));
      end else begin
        w.end_x = 8'(w.start_x + $urandom_range(24) - 12);
        w.end_y = 8'(w.start_y + $urandom_range(24) - 12);
      end
    end else if (pick < 52) begin
      w.operation = OP_CIRCLE;
      w.radius = 8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(20));
    end else if (pick < 54) w.operation = OP_CLEAR;
    else if (pick < 97) begin
      w.operation = OP_READ;
      w.start_x = 8'(($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(127));
    end else w.operation = 3'($urandom_range(7, 5));
    return w;
  endfunction

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    idle_pct = 28;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: field extremes, every command, clipping, circle wrap, zero radius,
    // lines going up and left, a single-point line, out of range reads, unknown codes.
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_PLOT, 0, 0, 0, 0, 0, 1, 0));
    send_word(make_word(OP_PLOT, 127, 63, 255, 255, 255, 1, 7));
    send_word(make_word(OP_PLOT, 128, 64, 0, 0, 0, 1, 0));
    send_word(make_word(OP_PLOT, 255, 255, 0, 0, 0, 1, 0));
    send_word(make_word(OP_READ, 127, 0, 0, 0, 0, 0, 7));
    send_word(make_word(OP_PLOT, 127, 63, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 127, 0, 0, 0, 0, 0, 7));
    send_word(make_word(OP_LINE, 100, 50, 10, 5, 0, 0, 0));
    send_word(make_word(OP_LINE, 5, 60, 120, 2, 0, 0, 0));
    send_word(make_word(OP_LINE, 40, 30, 40, 30, 0, 0, 0));
    send_word(make_word(OP_LINE, 0, 0, 255, 255, 0, 0, 0));
    send_word(make_word(OP_READ, 10, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_CIRCLE, 64, 32, 0, 0, 0, 0, 0));
    send_word(make_word(OP_CIRCLE, 2, 3, 0, 0, 10, 0, 0));
    send_word(make_word(OP_CIRCLE, 250, 250, 0, 0, 12, 0, 0));
    send_word(make_word(OP_CIRCLE, 64, 32, 0, 0, 255, 0, 0));
    send_word(make_word(OP_READ, 12, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 128, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 255, 0, 0, 0, 0, 0, 7));
    send_word(make_word(3'd5, 1, 1, 1, 1, 1, 1, 1));
    send_word(make_word(3'd7, 255, 255, 255, 255, 255, 1, 7));
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 64, 0, 0, 0, 0, 0, 4));
    in_valid_i <= 1'b0;

    // Hold off until every expected word has come back.
    wait (pending_count == 0);

    for (int n = 0; n < 1400; n++) begin
      // A calm stretch with no idling on either side.
      idle_pct = (n >= 600 && n < 800) ? 0 : 28;
      send_word(random_word());
    end
    in_valid_i <= 1'b0;

    wait (pending_count == 0);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
